// ----- hw/rtl/voxel_cube_frame_buffer_macros.svh -----
// Assertion macros for the voxel cube frame buffer checker.
// Needs nothing else; included by the checker file only.
`ifndef VOXEL_CUBE_FRAME_BUFFER_MACROS_SVH
`define VOXEL_CUBE_FRAME_BUFFER_MACROS_SVH

// Same-cycle implication, switched off while the kill condition holds.
`define VCFB_ASSERT_NOW(label, clk, kill, ante, cons) \
   label: assert property (@(posedge clk) disable iff (kill) (ante) |-> (cons)) \
      else $error("voxel cube frame buffer: same-cycle check failed");

// Next-cycle implication, switched off while the kill condition holds.
`define VCFB_ASSERT_NEXT(label, clk, kill, ante, cons) \
   label: assert property (@(posedge clk) disable iff (kill) (ante) |=> (cons)) \
      else $error("voxel cube frame buffer: next-cycle check failed");

`endif

// ----- hw/rtl/vcfb_pkg.sv -----
// Shared types and constants of the voxel cube frame buffer.
// Used by the decoder, the word cells, the top level and the checker.
package vcfb_pkg;

   // Default side length of the cube in voxels.
   localparam int CUBE_SIDE_DEFAULT = 8;

   // Field widths fixed by the command format.
   localparam int COORD_W = 3;
   localparam int AXIS_W  = 2;
   localparam int SIZE_W  = 4;
   // Wide enough for a corner plus an edge length, and for any cube index.
   localparam int SPAN_W  = 5;

   // Command codes.
   typedef enum logic [2:0] {
      OP_SET       = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_READ      = 3'd2,
      OP_PLANE     = 3'd3,
      OP_SHIFT     = 3'd4,
      OP_CLEAR_ALL = 3'd5,
      OP_FILL_ALL  = 3'd6,
      OP_WIRE      = 3'd7
   } op_type;

   // Plane fill axes; the fourth code fills nothing.
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Shift directions; the two remaining codes leave the store alone.
   typedef enum logic [2:0] {
      DIR_POS_X = 3'd0,
      DIR_NEG_X = 3'd1,
      DIR_POS_Y = 3'd2,
      DIR_NEG_Y = 3'd3,
      DIR_POS_Z = 3'd4,
      DIR_NEG_Z = 3'd5
   } dir_type;

   // Decoded command, broadcast to every word cell.
   typedef struct packed {
      logic                enable;
      op_type              op;
      logic [COORD_W-1:0]  pos_y;
      logic [COORD_W-1:0]  pos_z;
      axis_type            plane_axis;
      logic [COORD_W-1:0]  plane_index;
      dir_type             direction;
      logic                wire_on;
      logic [SPAN_W-1:0]   wire_hi_y;
      logic [SPAN_W-1:0]   wire_hi_z;
   } cmd_type;

endpackage

// ----- hw/rtl/vcfb_decode.sv -----
// Command decoder: turns one accepted item into the broadcast command and bit masks.
// Depends on vcfb_pkg.
module vcfb_decode #(
   parameter int CUBE_SIDE = vcfb_pkg::CUBE_SIDE_DEFAULT
) (
   input  logic                          accept,
   input  logic [2:0]                    req_operation,
   input  logic [vcfb_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [vcfb_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [vcfb_pkg::COORD_W-1:0]  req_pos_z,
   input  logic [vcfb_pkg::AXIS_W-1:0]   req_plane_axis,
   input  logic [vcfb_pkg::COORD_W-1:0]  req_plane_index,
   input  logic [2:0]                    req_direction,
   input  logic [vcfb_pkg::SIZE_W-1:0]   req_edge_size,
   output vcfb_pkg::cmd_type             cmd,
   output logic [CUBE_SIDE-1:0]          pos_mask,
   output logic [CUBE_SIDE-1:0]          plane_mask,
   output logic [CUBE_SIDE-1:0]          wire_span_x,
   output logic [CUBE_SIDE-1:0]          wire_edge_x
);

   logic [vcfb_pkg::SPAN_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, ext;

   // Far corner of the wireframe: corner plus size minus one.
   assign ext  = vcfb_pkg::SPAN_W'(req_edge_size) - vcfb_pkg::SPAN_W'(1);
   assign lo_x = vcfb_pkg::SPAN_W'(req_pos_x);
   assign lo_y = vcfb_pkg::SPAN_W'(req_pos_y);
   assign lo_z = vcfb_pkg::SPAN_W'(req_pos_z);
   assign hi_x = lo_x + ext;
   assign hi_y = lo_y + ext;
   assign hi_z = lo_z + ext;

   // Broadcast command.
   always_comb begin
      cmd.enable      = accept;
      cmd.op          = vcfb_pkg::op_type'(req_operation);
      cmd.pos_y       = req_pos_y;
      cmd.pos_z       = req_pos_z;
      cmd.plane_axis  = vcfb_pkg::axis_type'(req_plane_axis);
      cmd.plane_index = req_plane_index;
      cmd.direction   = vcfb_pkg::dir_type'(req_direction);
      cmd.wire_on     = (req_edge_size != '0);
      cmd.wire_hi_y   = hi_y;
      cmd.wire_hi_z   = hi_z;
   end

   // Bit masks along x, shared by all cells. Bits beyond the cube simply do not exist.
   always_comb begin
      for (int b = 0; b < CUBE_SIDE; b++) begin
         pos_mask[b]    = (lo_x == vcfb_pkg::SPAN_W'(b));
         plane_mask[b]  = (vcfb_pkg::SPAN_W'(req_plane_index) == vcfb_pkg::SPAN_W'(b));
         wire_span_x[b] = (lo_x <= vcfb_pkg::SPAN_W'(b)) && (vcfb_pkg::SPAN_W'(b) <= hi_x);
         wire_edge_x[b] = (lo_x == vcfb_pkg::SPAN_W'(b)) || (hi_x == vcfb_pkg::SPAN_W'(b));
      end
   end

endmodule

// ----- hw/rtl/vcfb_cell.sv -----
// One word cell of the voxel store: holds the x-bits of one (y, z) line.
// Depends on vcfb_pkg; neighbour words come from the adjacent cells.
module vcfb_cell #(
   parameter int CUBE_SIDE = vcfb_pkg::CUBE_SIDE_DEFAULT,
   parameter int ROW       = 0,
   parameter int COL       = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vcfb_pkg::cmd_type     cmd,
   input  logic [CUBE_SIDE-1:0]  pos_mask,
   input  logic [CUBE_SIDE-1:0]  plane_mask,
   input  logic [CUBE_SIDE-1:0]  wire_span_x,
   input  logic [CUBE_SIDE-1:0]  wire_edge_x,
   input  logic [CUBE_SIDE-1:0]  next_row_word,
   input  logic [CUBE_SIDE-1:0]  prev_row_word,
   input  logic [CUBE_SIDE-1:0]  next_col_word,
   input  logic [CUBE_SIDE-1:0]  prev_col_word,
   output logic [CUBE_SIDE-1:0]  word,
   output logic                  read_hit
);

   // Voxel coordinates that this cell stands for.
   localparam logic [vcfb_pkg::SPAN_W-1:0] MY_Y = vcfb_pkg::SPAN_W'(CUBE_SIDE - 1 - ROW);
   localparam logic [vcfb_pkg::SPAN_W-1:0] MY_Z = vcfb_pkg::SPAN_W'(CUBE_SIDE - 1 - COL);

   logic [CUBE_SIDE-1:0] word_ff, word_in, wire_mask;
   logic [vcfb_pkg::SPAN_W-1:0] lo_y, lo_z;
   logic hit_y, hit_z, yz_hit, edge_y, edge_z, span_y, span_z;

   assign lo_y   = vcfb_pkg::SPAN_W'(cmd.pos_y);
   assign lo_z   = vcfb_pkg::SPAN_W'(cmd.pos_z);
   assign hit_y  = (lo_y == MY_Y);
   assign hit_z  = (lo_z == MY_Z);
   assign yz_hit = hit_y && hit_z;

   // Wireframe: a voxel lies on an edge when two coordinates sit on the
   // cube's faces and all three lie within its span.
   assign edge_y = hit_y || (cmd.wire_hi_y == MY_Y);
   assign edge_z = hit_z || (cmd.wire_hi_z == MY_Z);
   assign span_y = (lo_y <= MY_Y) && (MY_Y <= cmd.wire_hi_y);
   assign span_z = (lo_z <= MY_Z) && (MY_Z <= cmd.wire_hi_z);

   always_comb begin
      wire_mask = '0;
      if (cmd.wire_on && span_y && span_z) begin
         if (edge_y && edge_z) begin
            wire_mask = wire_span_x;
         end else if (edge_y || edge_z) begin
            wire_mask = wire_span_x & wire_edge_x;
         end
      end
   end

   // Next value of the word for each command.
   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         vcfb_pkg::OP_SET: begin
            if (yz_hit) word_in = word_ff | pos_mask;
         end
         vcfb_pkg::OP_CLEAR: begin
            if (yz_hit) word_in = word_ff & ~pos_mask;
         end
         vcfb_pkg::OP_READ: begin
            word_in = word_ff;
         end
         vcfb_pkg::OP_PLANE: begin
            case (cmd.plane_axis)
               vcfb_pkg::AXIS_X: word_in = word_ff | plane_mask;
               vcfb_pkg::AXIS_Y: begin
                  if (vcfb_pkg::SPAN_W'(cmd.plane_index) == MY_Y) word_in = '1;
               end
               vcfb_pkg::AXIS_Z: begin
                  if (vcfb_pkg::SPAN_W'(cmd.plane_index) == MY_Z) word_in = '1;
               end
               default: word_in = word_ff;
            endcase
         end
         vcfb_pkg::OP_SHIFT: begin
            case (cmd.direction)
               vcfb_pkg::DIR_POS_X: word_in = word_ff << 1;
               vcfb_pkg::DIR_NEG_X: word_in = word_ff >> 1;
               vcfb_pkg::DIR_POS_Y: word_in = next_row_word;
               vcfb_pkg::DIR_NEG_Y: word_in = prev_row_word;
               vcfb_pkg::DIR_POS_Z: word_in = next_col_word;
               vcfb_pkg::DIR_NEG_Z: word_in = prev_col_word;
               default:             word_in = word_ff;
            endcase
         end
         vcfb_pkg::OP_CLEAR_ALL: word_in = '0;
         vcfb_pkg::OP_FILL_ALL:  word_in = '1;
         vcfb_pkg::OP_WIRE:      word_in = word_ff | wire_mask;
         default:                word_in = word_ff;
      endcase
   end

   // Word register, updated only by an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else if (cmd.enable) begin
         word_ff <= word_in;
      end
   end

   assign word     = word_ff;
   assign read_hit = (cmd.op == vcfb_pkg::OP_READ) && yz_hit && |(word_ff & pos_mask);

endmodule

// ----- hw/rtl/voxel_cube_frame_buffer.sv -----
// Voxel cube frame buffer: a grid of word cells, one per (y, z) line, plus a result register.
// Depends on vcfb_pkg, vcfb_decode and vcfb_cell.
// The result of an item is registered and appears in the cycle after it is accepted.
// Throughput: one item per cycle while no result is held back; every cell updates its own word in parallel.
// Reset: synchronous; clears all voxels and empties the result register.
module voxel_cube_frame_buffer #(
   parameter int CUBE_SIDE = vcfb_pkg::CUBE_SIDE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_operation,
   input  logic [vcfb_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [vcfb_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [vcfb_pkg::COORD_W-1:0]  req_pos_z,
   input  logic [vcfb_pkg::AXIS_W-1:0]   req_plane_axis,
   input  logic [vcfb_pkg::COORD_W-1:0]  req_plane_index,
   input  logic [2:0]                    req_direction,
   input  logic [vcfb_pkg::SIZE_W-1:0]   req_edge_size,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_voxel_lit
);

   localparam int CELLS = CUBE_SIDE * CUBE_SIDE;

   vcfb_pkg::cmd_type     cmd;
   logic [CUBE_SIDE-1:0]  pos_mask, plane_mask, wire_span_x, wire_edge_x;
   logic [CUBE_SIDE-1:0]  cell_word [CELLS];
   logic [CELLS-1:0]      read_hit;
   logic                  accept;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_voxel_lit_ff, rsp_voxel_lit_in;

   // An item is taken unless a finished result is still held back.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   vcfb_decode #(
      .CUBE_SIDE (CUBE_SIDE)
   ) u_decode (
      .accept          (accept),
      .req_operation   (req_operation),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_plane_axis  (req_plane_axis),
      .req_plane_index (req_plane_index),
      .req_direction   (req_direction),
      .req_edge_size   (req_edge_size),
      .cmd             (cmd),
      .pos_mask        (pos_mask),
      .plane_mask      (plane_mask),
      .wire_span_x     (wire_span_x),
      .wire_edge_x     (wire_edge_x)
   );

   // Grid of word cells; each one is wired to its four neighbours, and
   // cells at the border see zero where the store has no neighbour.
   for (genvar r = 0; r < CUBE_SIDE; r++) begin : g_row
      for (genvar c = 0; c < CUBE_SIDE; c++) begin : g_col
         localparam int IDX = r * CUBE_SIDE + c;
         logic [CUBE_SIDE-1:0] next_row_word, prev_row_word, next_col_word, prev_col_word;

         if (r + 1 < CUBE_SIDE) begin : g_nr
            assign next_row_word = cell_word[IDX + CUBE_SIDE];
         end else begin : g_nr_edge
            assign next_row_word = '0;
         end
         if (r > 0) begin : g_pr
            assign prev_row_word = cell_word[IDX - CUBE_SIDE];
         end else begin : g_pr_edge
            assign prev_row_word = '0;
         end
         if (c + 1 < CUBE_SIDE) begin : g_nc
            assign next_col_word = cell_word[IDX + 1];
         end else begin : g_nc_edge
            assign next_col_word = '0;
         end
         if (c > 0) begin : g_pc
            assign prev_col_word = cell_word[IDX - 1];
         end else begin : g_pc_edge
            assign prev_col_word = '0;
         end

         vcfb_cell #(
            .CUBE_SIDE (CUBE_SIDE),
            .ROW       (r),
            .COL       (c)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .cmd           (cmd),
            .pos_mask      (pos_mask),
            .plane_mask    (plane_mask),
            .wire_span_x   (wire_span_x),
            .wire_edge_x   (wire_edge_x),
            .next_row_word (next_row_word),
            .prev_row_word (prev_row_word),
            .next_col_word (next_col_word),
            .prev_col_word (prev_col_word),
            .word          (cell_word[IDX]),
            .read_hit      (read_hit[IDX])
         );
      end
   end

   // Result register: loads on accept, holds while the consumer stalls.
   assign rsp_valid_in     = accept || (rsp_valid_ff && rsp_stall);
   assign rsp_voxel_lit_in = accept ? (|read_hit) : rsp_voxel_lit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_voxel_lit_ff <= rsp_voxel_lit_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_voxel_lit = rsp_voxel_lit_ff;

endmodule

// ----- hw/rtl/vcfb_checker.sv -----
// Port-level checker for the voxel cube frame buffer, bound to the top level.
// Depends on vcfb_pkg and voxel_cube_frame_buffer_macros.svh.
`include "voxel_cube_frame_buffer_macros.svh"

module vcfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_voxel_lit
);

   logic take_other, rsp_held;

   // An accepted item that is not a read, and a result that is held back.
   assign take_other = req_valid && !req_stall && (req_operation != vcfb_pkg::OP_READ);
   assign rsp_held   = rsp_valid && rsp_stall;

   // After reset the result register is empty.
   `VCFB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // Every accepted item gives a result in the next cycle.
   `VCFB_ASSERT_NEXT(a_accept_result, clock, reset, req_valid && !req_stall, rsp_valid)

   // Only a read can report a lit voxel.
   `VCFB_ASSERT_NEXT(a_lit_only_read, clock, reset, take_other, !rsp_voxel_lit)

   // Input stalls only while a result is held back.
   `VCFB_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A stalled result stays and keeps its value.
   `VCFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_voxel_lit))

endmodule

bind voxel_cube_frame_buffer vcfb_checker u_checker (.*);
